// File: sv/rdm_pkg.sv
// rdm_pkg: constants, opcodes and unit handshake types of the routing density map
// no dependencies; used by rdm_ifs, routing_density_map_top, rdm_div and rdm_satadd
package rdm_pkg;

  localparam int MAX_SIDE   = 64;
  localparam int FRAC_BITS  = 16;
  localparam int COORD_W    = 6;
  localparam int SIDE_W     = 7;
  localparam int CELL_W     = 32;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int CELL_DEPTH = 1 << ADDR_W;

  // divider operands: (w+h+1) << FRAC_BITS over (w+1)*(h+1)
  localparam int NUM_W     = COORD_W + 1 + FRAC_BITS;
  localparam int DEN_W     = 2 * COORD_W + 1;
  localparam int QUO_W     = FRAC_BITS + 1;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);
  localparam int DELTA_W   = FRAC_BITS + 2;

  // apb register file
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_GRID_SIDE = '0;
  localparam logic [SIDE_W-1:0]    GRID_SIDE_RST = SIDE_W'(32);

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_RECT  = 2'd1,
    OP_OCC   = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [QUO_W-1:0] quo;
  } div_rsp_t;

endpackage

// File: sv/rdm_ifs.sv
// rdm_in_if / rdm_out_if: valid-ready channels of the routing density map
// depends on rdm_pkg for field widths
interface rdm_in_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  opcode;
  logic [rdm_pkg::COORD_W-1:0] x_min;
  logic [rdm_pkg::COORD_W-1:0] y_min;
  logic [rdm_pkg::COORD_W-1:0] x_max;
  logic [rdm_pkg::COORD_W-1:0] y_max;
  logic                        subtract;
  logic                        occupancy;

  modport source (output valid, opcode, x_min, y_min, x_max, y_max, subtract, occupancy,
                  input ready);
  modport sink   (input valid, opcode, x_min, y_min, x_max, y_max, subtract, occupancy,
                  output ready);
endinterface

interface rdm_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [rdm_pkg::CELL_W-1:0] cell_value;
  logic                              saturated;

  modport source (output valid, cell_value, saturated, input ready);
  modport sink   (input valid, cell_value, saturated, output ready);
endinterface

// File: sv/routing_density_map_top.sv
// routing_density_map_top: grid of q16.16 congestion cells with rectangle and cell updates
// depends on rdm_pkg, rdm_ifs, rdm_ram, rdm_div, rdm_satadd
// throughput one word at a time, set by the 23-step divider and one cell read-modify-write
//   per cycle on the cell ram's write port and registered read port
// reset: grid_side returns to 32 and a clearing pass zeroes all 4096 cells, one per cycle,
//   with in_ch.ready low until the pass ends; apb writes are taken throughout
module routing_density_map_top (
  input  logic                          clk,
  input  logic                          rst_n,
  rdm_in_if.sink                        in_ch,
  rdm_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rdm_pkg::PADDR_W-1:0]   paddr,
  input  logic [rdm_pkg::PDATA_W-1:0]   pwdata,
  output logic [rdm_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  import rdm_pkg::*;

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_CLEAR, S_DIV, S_WALK, S_DRAIN, S_RDATA, S_DONE
  } state_t;

  state_t                     state_r, state_nxt;
  logic [SIDE_W-1:0]          grid_side_r, grid_side_nxt;
  logic [ADDR_W-1:0]          clr_addr_r, clr_addr_nxt;
  logic [COORD_W-1:0]         cx_r, cx_nxt;
  logic [COORD_W-1:0]         cy_r, cy_nxt;
  logic [COORD_W-1:0]         x_lo_r, x_lo_nxt;
  logic [COORD_W-1:0]         x_hi_r, x_hi_nxt;
  logic [COORD_W-1:0]         y_hi_r, y_hi_nxt;
  logic                       sub_r, sub_nxt;
  logic signed [DELTA_W-1:0]  delta_r, delta_nxt;
  logic                       wb_vld_r, wb_vld_nxt;
  logic [ADDR_W-1:0]          wb_addr_r, wb_addr_nxt;
  logic [CELL_W-1:0]          val_r, val_nxt;
  logic                       sat_r, sat_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [CELL_W-1:0]          out_value_r, out_value_nxt;
  logic                       out_sat_r, out_sat_nxt;

  // side in use and clipping of the incoming word
  logic [SIDE_W-1:0]          side;
  logic [COORD_W-1:0]         side_m1;
  logic [COORD_W-1:0]         xe, ye;
  logic                       cell_in_grid;
  logic                       box_ok;
  logic [COORD_W-1:0]         w, h;
  logic [COORD_W:0]           w1, h1;
  logic [2*COORD_W+1:0]       den_full;
  logic                       accept;
  op_t                        op;

  // cell store, divider and saturating adder
  logic                       ram_we, ram_re;
  logic [ADDR_W-1:0]          ram_waddr, ram_raddr;
  logic [CELL_W-1:0]          ram_wdata, ram_rdata;
  logic signed [CELL_W-1:0]   sum;
  logic                       clamp;
  div_req_t                   div_req;
  div_rsp_t                   div_rsp;
  logic [DELTA_W-1:0]         quo_ext;
  logic                       last_cell;
  logic                       clr_last;
  logic                       cfg_wr;
  logic [REG_IDX_W-1:0]       reg_idx;

  // grid_side 0 acts as 1, anything past the maximum acts as the maximum
  always_comb begin
    if (grid_side_r == '0) begin
      side = SIDE_W'(1);
    end else if (grid_side_r > SIDE_W'(MAX_SIDE)) begin
      side = SIDE_W'(MAX_SIDE);
    end else begin
      side = grid_side_r;
    end
  end

  assign side_m1 = COORD_W'(side - 1'b1);
  assign xe      = ({1'b0, in_ch.x_max} < side) ? in_ch.x_max : side_m1;
  assign ye      = ({1'b0, in_ch.y_max} < side) ? in_ch.y_max : side_m1;

  assign cell_in_grid = ({1'b0, in_ch.x_min} < side) && ({1'b0, in_ch.y_min} < side);

  // box must be upright and keep at least one cell after clipping
  assign box_ok = (in_ch.x_min <= in_ch.x_max) && (in_ch.y_min <= in_ch.y_max) &&
                  (in_ch.x_min <= xe) && (in_ch.y_min <= ye);

  // density operands come from the unclipped box
  assign w        = in_ch.x_max - in_ch.x_min;
  assign h        = in_ch.y_max - in_ch.y_min;
  assign w1       = {1'b0, w} + 1'b1;
  assign h1       = {1'b0, h} + 1'b1;
  assign den_full = w1 * h1;

  assign op     = op_t'(in_ch.opcode);
  assign accept = in_ch.valid && in_ch.ready;

  assign in_ch.ready = (state_r == S_IDLE);

  assign div_req.start = accept && (op == OP_RECT) && box_ok;
  assign div_req.num   = {{1'b0, w} + {1'b0, h} + 1'b1, {FRAC_BITS{1'b0}}};
  assign div_req.den   = den_full[DEN_W-1:0];

  rdm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign quo_ext = DELTA_W'(div_rsp.quo);

  // cell address is {row, column}
  assign ram_re    = (state_r == S_WALK) || (accept && (op == OP_READ) && cell_in_grid);
  assign ram_raddr = (state_r == S_WALK) ? {cy_r, cx_r} : {in_ch.y_min, in_ch.x_min};

  // clearing pass owns the write port, otherwise the writeback stage
  always_comb begin
    if ((state_r == S_INIT) || (state_r == S_CLEAR)) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = wb_vld_r;
      ram_waddr = wb_addr_r;
      ram_wdata = sum;
    end
  end

  rdm_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read data of the cell issued last cycle meets the delta here
  rdm_satadd u_sat (
    .cur   (ram_rdata),
    .delta (delta_r),
    .sum   (sum),
    .clamp (clamp)
  );

  assign last_cell = (cx_r == x_hi_r) && (cy_r == y_hi_r);
  assign clr_last  = (clr_addr_r == {ADDR_W{1'b1}});

  // apb: one register, pready tied high
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready && (reg_idx == REG_GRID_SIDE);
  assign prdata  = (reg_idx == REG_GRID_SIDE) ? PDATA_W'(grid_side_r) : '0;

  function automatic logic signed [DELTA_W-1:0] sub_sel(input logic s,
                                                        input logic [DELTA_W-1:0] q);
    logic [DELTA_W-1:0] neg;
    neg = DELTA_W'(0) - q;
    return s ? neg : q;
  endfunction

  always_comb begin
    state_nxt     = state_r;
    grid_side_nxt = cfg_wr ? pwdata[SIDE_W-1:0] : grid_side_r;
    clr_addr_nxt  = clr_addr_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    x_lo_nxt      = x_lo_r;
    x_hi_nxt      = x_hi_r;
    y_hi_nxt      = y_hi_r;
    sub_nxt       = sub_r;
    delta_nxt     = delta_r;
    wb_vld_nxt    = 1'b0;
    wb_addr_nxt   = wb_addr_r;
    val_nxt       = val_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_sat_nxt   = out_sat_r;

    // any clamp in the writeback stage sticks for this word
    if (wb_vld_r && clamp) begin
      sat_nxt = 1'b1;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          val_nxt = '0;
          sat_nxt = 1'b0;
          sub_nxt = in_ch.subtract;
          unique case (op)
            OP_CLEAR: begin
              clr_addr_nxt = '0;
              state_nxt    = S_CLEAR;
            end
            OP_RECT: begin
              cx_nxt   = in_ch.x_min;
              cy_nxt   = in_ch.y_min;
              x_lo_nxt = in_ch.x_min;
              x_hi_nxt = xe;
              y_hi_nxt = ye;
              state_nxt = box_ok ? S_DIV : S_DONE;
            end
            OP_OCC: begin
              cx_nxt    = in_ch.x_min;
              cy_nxt    = in_ch.y_min;
              x_lo_nxt  = in_ch.x_min;
              x_hi_nxt  = in_ch.x_min;
              y_hi_nxt  = in_ch.y_min;
              delta_nxt = DELTA_W'(in_ch.occupancy) << FRAC_BITS;
              state_nxt = cell_in_grid ? S_WALK : S_DONE;
            end
            OP_READ: begin
              state_nxt = cell_in_grid ? S_RDATA : S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_last) begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          delta_nxt = sub_sel(sub_r, quo_ext);
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        // issue the read now, write the updated cell next cycle
        wb_vld_nxt  = 1'b1;
        wb_addr_nxt = {cy_r, cx_r};
        if (cx_r == x_hi_r) begin
          cx_nxt = x_lo_r;
          cy_nxt = cy_r + 1'b1;
        end else begin
          cx_nxt = cx_r + 1'b1;
        end
        if (last_cell) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_RDATA: begin
        val_nxt   = ram_rdata;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = val_r;
          out_sat_nxt   = sat_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      grid_side_r <= GRID_SIDE_RST;
      clr_addr_r  <= '0;
      wb_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      grid_side_r <= grid_side_nxt;
      clr_addr_r  <= clr_addr_nxt;
      wb_vld_r    <= wb_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    x_lo_r      <= x_lo_nxt;
    x_hi_r      <= x_hi_nxt;
    y_hi_r      <= y_hi_nxt;
    sub_r       <= sub_nxt;
    delta_r     <= delta_nxt;
    wb_addr_r   <= wb_addr_nxt;
    val_r       <= val_nxt;
    sat_r       <= sat_nxt;
    out_value_r <= out_value_nxt;
    out_sat_r   <= out_sat_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_value = out_value_r;
  assign out_ch.saturated  = out_sat_r;

`ifndef SYNTHESIS
  // a writeback always follows a walk read
  a_wb_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    wb_vld_r |-> $past(state_r == S_WALK))
    else $error("writeback without a preceding walk read");

  // the walk never reads the cell that is being written back
  a_no_rmw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (wb_vld_r && ram_re) |-> (ram_raddr != wb_addr_r))
    else $error("read of a cell with its writeback pending");

  // the divider only finishes while the sequencer waits for it
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_DIV))
    else $error("divider finished outside the divide wait");

  // no writeback pending and the divider idle when a new word can be taken
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!wb_vld_r && !div_rsp.busy))
    else $error("idle with work still in flight");
`endif

endmodule

// File: sv/rdm_ram.sv
// rdm_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module rdm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/rdm_div.sv
// rdm_div: restoring divider, one quotient bit per cycle
// depends on rdm_pkg (operand widths, div_req_t, div_rsp_t)
module rdm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rdm_pkg::div_req_t req,
  output rdm_pkg::div_rsp_t rsp
);
  import rdm_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]     dq_r, dq_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 ge;

  assign trial = {rem_r, dq_r[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dq_nxt  = {dq_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(NUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    den_r <= den_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quo  = dq_r[QUO_W-1:0];

endmodule

// File: sv/rdm_satadd.sv
// rdm_satadd: saturating add of a signed delta to one q16.16 cell
// depends on rdm_pkg (CELL_W, DELTA_W)
module rdm_satadd (
  input  logic signed [rdm_pkg::CELL_W-1:0]  cur,
  input  logic signed [rdm_pkg::DELTA_W-1:0] delta,
  output logic signed [rdm_pkg::CELL_W-1:0]  sum,
  output logic                               clamp
);
  import rdm_pkg::*;

  logic signed [CELL_W:0] wide;

  assign wide  = {cur[CELL_W-1], cur} + (CELL_W + 1)'(delta);
  assign clamp = wide[CELL_W] != wide[CELL_W-1];

  always_comb begin
    if (!clamp) begin
      sum = wide[CELL_W-1:0];
    end else if (wide[CELL_W]) begin
      sum = {1'b1, {(CELL_W-1){1'b0}}};
    end else begin
      sum = {1'b0, {(CELL_W-1){1'b1}}};
    end
  end

endmodule
